// ===== rtl/clsrng_pkg.sv =====
// Shared constants, types and structs for the combined LCG shuffle generator.
`default_nettype none

package clsrng_pkg;

  localparam int unsigned GEN_W  = 31;  // generator / sample width
  localparam int unsigned FRAC_W = 32;  // Q0.32 fraction width
  localparam int unsigned MOP_W  = 16;  // narrow multiplier operand
  localparam int unsigned PROD_W = 47;  // MOP_W + GEN_W
  localparam int unsigned FOLD_W = 8;   // 2^31 - modulus fits here

  localparam logic [GEN_W-1:0]  MOD_A        = 31'd2147483563;
  localparam logic [GEN_W-1:0]  MOD_B        = 31'd2147483399;
  localparam logic [GEN_W-1:0]  TOP_A        = 31'd2147483562;
  localparam logic [FOLD_W-1:0] FOLD_A       = 8'd85;   // 2^31 - MOD_A
  localparam logic [FOLD_W-1:0] FOLD_B       = 8'd249;  // 2^31 - MOD_B
  localparam logic [MOP_W-1:0]  MUL_A        = 16'd40014;
  localparam logic [MOP_W-1:0]  MUL_B        = 16'd40692;
  localparam logic [MOP_W-1:0]  FRAC_MUL     = 16'd170; // 2^32 - 2*MOD_A
  localparam logic [FRAC_W-1:0] FRAC_MAX     = 32'd4294966780;
  localparam logic [GEN_W-1:0]  FIRST_RESET  = 31'd1;
  localparam logic [GEN_W-1:0]  SECOND_RESET = 31'd123456789;

  typedef enum logic {
    MOD_SEL_A,
    MOD_SEL_B
  } mod_sel_e;

  // Operands for the shared multiply/fold unit.
  typedef struct packed {
    logic [MOP_W-1:0] a;
    logic [GEN_W-1:0] b;
    mod_sel_e         sel;
  } mul_op_t;

  // Registered product plus its residue; wrap flags the final subtract.
  typedef struct packed {
    logic [PROD_W-1:0] prod;
    logic [GEN_W-1:0]  rem;
    logic              wrap;
  } mul_res_t;

endpackage

`default_nettype wire

// ===== rtl/clsrng_req_if.sv =====
// Request channel: draw or seed-then-draw words.
`default_nettype none

interface clsrng_req_if import clsrng_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             func;
  logic [GEN_W-1:0] seed_value;

  modport source (output valid, func, seed_value, input ready);
  modport sink   (input valid, func, seed_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/clsrng_rsp_if.sv =====
// Response channel: sample and Q0.32 fraction words.
`default_nettype none

interface clsrng_rsp_if import clsrng_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [GEN_W-1:0]  sample;
  logic [FRAC_W-1:0] fraction;

  modport source (output valid, sample, fraction, input ready);
  modport sink   (input valid, sample, fraction, output ready);
endinterface

`default_nettype wire

// ===== rtl/clsrng_mul_unit.sv =====
// Shared 16x31 multiplier with registered product and modular fold stage.
`default_nettype none

module clsrng_mul_unit import clsrng_pkg::*; (
  input  logic     clk_i,
  input  mul_op_t  op_i,
  output mul_res_t res_o
);

  logic [PROD_W-1:0] prod_q;
  mod_sel_e          sel_q;

  logic [MOP_W-1:0]        hi;
  logic [FOLD_W-1:0]       fold;
  logic [GEN_W-1:0]        modulus;
  logic [GEN_W:0]          sum;
  logic [GEN_W:0]          sum_sub;
  logic                    wrap;

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(op_i.a) * PROD_W'(op_i.b);
    sel_q  <= op_i.sel;
  end

  // p = hi*2^31 + lo == hi*(2^31 - M) + lo  (mod M); result < 2M
  always_comb begin
    hi      = prod_q[PROD_W-1:GEN_W];
    fold    = (sel_q == MOD_SEL_A) ? FOLD_A : FOLD_B;
    modulus = (sel_q == MOD_SEL_A) ? MOD_A : MOD_B;
    sum     = (GEN_W+1)'((MOP_W+FOLD_W)'(hi) * (MOP_W+FOLD_W)'(fold))
            + {1'b0, prod_q[GEN_W-1:0]};
    sum_sub = sum - {1'b0, modulus};
    wrap    = (sum >= {1'b0, modulus});
  end

  assign res_o.prod = prod_q;
  assign res_o.wrap = wrap;
  assign res_o.rem  = wrap ? sum_sub[GEN_W-1:0] : sum[GEN_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/clsrng_shuffle_mem.sv =====
// Shuffle table memory with per-entry valid bits; unwritten entries read zero.
`default_nettype none

module clsrng_shuffle_mem import clsrng_pkg::*; #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  logic [GEN_W-1:0] wdata_i,
  input  logic             re_i,
  input  logic [IDX_W-1:0] raddr_i,
  output logic [GEN_W-1:0] rdata_o
);

  logic [GEN_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [GEN_W-1:0] rdata_q;
  logic             rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

`default_nettype wire

// ===== rtl/combined_lcg_shuffle_rng.sv =====
// Combined two-modulus LCG with Bays-Durham shuffle table, iterative datapath.
// A draw word walks the slot, generator, mix and fraction states; a new word is taken only in idle,
// after the result enters the output word (held while that word is occupied). A seed word adds a warm-up.
// The single shared multiplier gives one product per cycle, folded next cycle.
// Reset: generators 1 and 123456789, last sample 0, table reads zero via valid bits.
// No clearing pass; the block takes a word in the first cycle after reset.
`default_nettype none

module combined_lcg_shuffle_rng import clsrng_pkg::*; #(
  parameter int unsigned TABLE_SIZE = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  clsrng_req_if.sink   req_i,
  clsrng_rsp_if.source rsp_o
);

  localparam int unsigned IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int unsigned Q_W   = $clog2(TABLE_SIZE + 2);
  localparam int unsigned CNT_W = $clog2(TABLE_SIZE + 8);

  // Slot divisor and its truncated reciprocal; estimate is low by at most one.
  localparam longint unsigned SLOT_DIV_L   = 64'd1 + 64'd2147483562 / TABLE_SIZE;
  localparam longint unsigned SLOT_RECIP_L = (64'd1 << 32) / SLOT_DIV_L;
  localparam logic [GEN_W-1:0] SLOT_DIV    = GEN_W'(SLOT_DIV_L);
  localparam logic [MOP_W-1:0] SLOT_RECIP  = MOP_W'(SLOT_RECIP_L);
  localparam logic [CNT_W-1:0] WARM_LAST   = CNT_W'(TABLE_SIZE + 7);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WARM_MUL,   // issue 40014*g1
    ST_WARM_RED,   // fold, fill table from the top slot down
    ST_SLOT_MUL,   // last * reciprocal
    ST_SLOT_CHK,   // estimate * divisor
    ST_SLOT_SEL,   // correct estimate, read table, issue g1 step
    ST_GEN_A,      // capture g1, issue g2 step
    ST_GEN_B,      // capture g2
    ST_MIX,        // subtract, wrap, refill slot
    ST_FRAC_MUL,   // 170 * sample
    ST_FRAC_OUT    // fraction = 2s + floor(170s / M), hand to output word
  } state_e;

  state_e            state_q, state_d;
  logic [GEN_W-1:0]  g1_q, g1_d;
  logic [GEN_W-1:0]  g2_q, g2_d;
  logic [GEN_W-1:0]  last_q, last_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [Q_W-1:0]    qest_q, qest_d;
  logic [IDX_W-1:0]  slot_q, slot_d;
  logic              out_valid_q, out_valid_d;
  logic [GEN_W-1:0]  sample_q, sample_d;
  logic [FRAC_W-1:0] frac_q, frac_d;

  mul_op_t  mul_op;
  mul_res_t mul_res;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [GEN_W-1:0] mem_wdata;
  logic             mem_re;
  logic [GEN_W-1:0] mem_rdata;

  logic [GEN_W-1:0]  seed_fix;
  logic [GEN_W-1:0]  slot_rem;
  logic [Q_W-1:0]    qfix;
  logic [IDX_W-1:0]  slot_w;
  logic [GEN_W:0]    mix_dif;
  logic [GEN_W:0]    mix_wrap;
  logic [GEN_W-1:0]  mix_val;
  logic [FRAC_W-1:0] frac_sum;
  logic [FRAC_W-1:0] frac_w;
  logic              req_acc;

  clsrng_mul_unit u_mul (
    .clk_i (clk_i),
    .op_i  (mul_op),
    .res_o (mul_res)
  );

  clsrng_shuffle_mem #(
    .DEPTH (TABLE_SIZE),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (slot_w),
    .rdata_o (mem_rdata)
  );

  assign req_acc = req_i.valid && req_i.ready;

  // Seed: zero becomes one, values at or above the first modulus saturate.
  assign seed_fix = (req_i.seed_value == '0)   ? GEN_W'(1) :
                    (req_i.seed_value >= MOD_A) ? TOP_A : req_i.seed_value;

  // Slot: estimate from the reciprocal, then one compare corrects it.
  assign slot_rem = last_q - mul_res.prod[GEN_W-1:0];
  assign qfix     = qest_q + Q_W'(slot_rem >= SLOT_DIV);
  assign slot_w   = (qfix >= Q_W'(TABLE_SIZE)) ? IDX_W'(TABLE_SIZE - 1) : qfix[IDX_W-1:0];

  // Table entry minus second generator, wrapped into 1..TOP_A.
  assign mix_dif  = {1'b0, mem_rdata} - {1'b0, g2_q};
  assign mix_wrap = mix_dif + {1'b0, TOP_A};
  assign mix_val  = (mem_rdata <= g2_q) ? mix_wrap[GEN_W-1:0] : mix_dif[GEN_W-1:0];

  // s*2^32 = 2*M*s + 170*s, so the fold's high part and wrap give the quotient.
  assign frac_sum = {last_q, 1'b0} + FRAC_W'(mul_res.prod[PROD_W-1:GEN_W])
                  + FRAC_W'(mul_res.wrap);
  assign frac_w   = (frac_sum > FRAC_MAX) ? FRAC_MAX : frac_sum;

  always_comb begin
    state_d     = state_q;
    g1_d        = g1_q;
    g2_d        = g2_q;
    last_d      = last_q;
    cnt_d       = cnt_q;
    qest_d      = qest_q;
    slot_d      = slot_q;
    out_valid_d = out_valid_q;
    sample_d    = sample_q;
    frac_d      = frac_q;
    mul_op      = '{a: MUL_A, b: g1_q, sel: MOD_SEL_A};
    mem_we      = 1'b0;
    mem_waddr   = slot_q;
    mem_wdata   = g1_q;
    mem_re      = 1'b0;

    if (rsp_o.valid && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          if (req_i.func) begin
            g1_d    = seed_fix;
            g2_d    = seed_fix;
            cnt_d   = WARM_LAST;
            state_d = ST_WARM_MUL;
          end else begin
            state_d = ST_SLOT_MUL;
          end
        end
      end
      ST_WARM_MUL: begin
        state_d = ST_WARM_RED;
      end
      ST_WARM_RED: begin
        g1_d = mul_res.rem;
        if (cnt_q < CNT_W'(TABLE_SIZE)) begin
          mem_we    = 1'b1;
          mem_waddr = cnt_q[IDX_W-1:0];
          mem_wdata = mul_res.rem;
        end
        if (cnt_q == '0) begin
          last_d  = mul_res.rem;
          state_d = ST_SLOT_MUL;
        end else begin
          cnt_d   = cnt_q - CNT_W'(1);
          state_d = ST_WARM_MUL;
        end
      end
      ST_SLOT_MUL: begin
        mul_op  = '{a: SLOT_RECIP, b: last_q, sel: MOD_SEL_A};
        state_d = ST_SLOT_CHK;
      end
      ST_SLOT_CHK: begin
        qest_d  = mul_res.prod[32 +: Q_W];
        mul_op  = '{a: MOP_W'(qest_d), b: SLOT_DIV, sel: MOD_SEL_A};
        state_d = ST_SLOT_SEL;
      end
      ST_SLOT_SEL: begin
        mem_re  = 1'b1;
        slot_d  = slot_w;
        state_d = ST_GEN_A;
      end
      ST_GEN_A: begin
        g1_d    = mul_res.rem;
        mul_op  = '{a: MUL_B, b: g2_q, sel: MOD_SEL_B};
        state_d = ST_GEN_B;
      end
      ST_GEN_B: begin
        g2_d    = mul_res.rem;
        state_d = ST_MIX;
      end
      ST_MIX: begin
        mem_we  = 1'b1;
        last_d  = mix_val;
        state_d = ST_FRAC_MUL;
      end
      ST_FRAC_MUL: begin
        mul_op  = '{a: FRAC_MUL, b: last_q, sel: MOD_SEL_A};
        state_d = ST_FRAC_OUT;
      end
      ST_FRAC_OUT: begin
        // keep the product alive while the output word is still occupied
        mul_op = '{a: FRAC_MUL, b: last_q, sel: MOD_SEL_A};
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          sample_d    = last_q;
          frac_d      = frac_w;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      g1_q        <= FIRST_RESET;
      g2_q        <= SECOND_RESET;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      g1_q        <= g1_d;
      g2_q        <= g2_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    qest_q   <= qest_d;
    slot_q   <= slot_d;
    sample_q <= sample_d;
    frac_q   <= frac_d;
  end

  assign req_i.ready    = (state_q == ST_IDLE);
  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.sample   = sample_q;
  assign rsp_o.fraction = frac_q;

  // one word in flight: an accepted request closes the input next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> !req_i.ready)
    else $error("request taken while a word is in progress");

  a_sample_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (sample_q != '0) && (sample_q <= TOP_A))
    else $error("sample outside 1..TOP_A");

  a_frac_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (frac_q <= FRAC_MAX))
    else $error("fraction above clamp");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MIX) |-> (slot_q <= IDX_W'(TABLE_SIZE - 1)))
    else $error("shuffle slot beyond table");

  a_gen_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MIX) |-> (g1_q < MOD_A) && (g2_q < MOD_B))
    else $error("generator not reduced");

endmodule

`default_nettype wire
